[design/mm4_pkg.sv]
package mm4_pkg;

    localparam int DEF_WIDTH     = 32;
    localparam int DEF_FRAC_BITS = 16;

    localparam int ELEM_COUNT = 16;
    localparam int ELEM_W     = 4;
    localparam int TERM_W     = 2;
    localparam int CNT_W      = ELEM_W + TERM_W;

    localparam logic [1:0] OP_WR_LEFT  = 2'd0;
    localparam logic [1:0] OP_WR_RIGHT = 2'd1;
    localparam logic [1:0] OP_MULTIPLY = 2'd2;

    localparam logic [TERM_W-1:0] TERM_FIRST = '0;
    localparam logic [TERM_W-1:0] TERM_LAST  = '1;
    localparam logic [ELEM_W-1:0] ELEM_LAST  = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic              wr_left;
        logic              wr_right;
        logic [ELEM_W-1:0] wr_addr;
        logic              issue;
        logic [ELEM_W-1:0] elem;
        logic [TERM_W-1:0] term;
    } dp_cmd_t;

    typedef struct packed {
        logic pipe_active;
    } dp_stat_t;

endpackage

[design/mm4_ctrl.sv]
module mm4_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         op,
    input  logic [1:0]         row,
    input  logic [1:0]         col,
    input  mm4_pkg::dp_stat_t  stat,
    output mm4_pkg::dp_cmd_t   cmd,
    output logic               busy
);

    mm4_pkg::state_t                state_reg;
    mm4_pkg::state_t                state_next;
    logic [mm4_pkg::CNT_W-1:0]      cnt_reg;
    logic [mm4_pkg::CNT_W-1:0]      cnt_next;
    logic                           accept;

    assign accept = start && (state_reg == mm4_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mm4_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mm4_pkg::ST_IDLE:
            begin
                if (accept && op == mm4_pkg::OP_MULTIPLY)
                    state_next = mm4_pkg::ST_RUN;
            end
            mm4_pkg::ST_RUN:
            begin
                if (cnt_reg == '1)
                    state_next = mm4_pkg::ST_DRAIN;
            end
            mm4_pkg::ST_DRAIN:
            begin
                if (!stat.pipe_active)
                    state_next = mm4_pkg::ST_IDLE;
            end
            default:
                state_next = mm4_pkg::ST_IDLE;
        endcase
    end

    // advance the term counter while issuing reads
    always_comb
    begin
        cnt_next = cnt_reg;
        case (state_reg)
            mm4_pkg::ST_RUN:   cnt_next = cnt_reg + 1'b1;
            default:           cnt_next = '0;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.wr_left  = 1'b0;
        cmd.wr_right = 1'b0;
        cmd.wr_addr  = {row, col};
        cmd.issue    = 1'b0;
        cmd.elem     = cnt_reg[mm4_pkg::CNT_W-1:mm4_pkg::TERM_W];
        cmd.term     = cnt_reg[mm4_pkg::TERM_W-1:0];
        busy         = 1'b1;
        case (state_reg)
            mm4_pkg::ST_IDLE:
            begin
                busy         = 1'b0;
                cmd.wr_left  = accept && (op == mm4_pkg::OP_WR_LEFT);
                cmd.wr_right = accept && (op == mm4_pkg::OP_WR_RIGHT);
            end
            mm4_pkg::ST_RUN:
                cmd.issue = 1'b1;
            mm4_pkg::ST_DRAIN:
                busy = 1'b1;
            default:
                busy = 1'b1;
        endcase
    end

endmodule

[design/mm4_datapath.sv]
module mm4_datapath #(
    parameter int WIDTH     = mm4_pkg::DEF_WIDTH,
    parameter int FRAC_BITS = mm4_pkg::DEF_FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mm4_pkg::dp_cmd_t    cmd,
    input  logic signed [31:0]  value,
    output mm4_pkg::dp_stat_t   stat,
    output logic                result_valid,
    output logic [1:0]          out_row,
    output logic [1:0]          out_col,
    output logic signed [31:0]  product,
    output logic                last
);

    localparam int PROD_W = 2 * WIDTH;
    localparam int ACC_W  = PROD_W + 2;
    localparam logic signed [WIDTH-1:0] SAT_MAX = {1'b0, {(WIDTH-1){1'b1}}};
    localparam logic signed [WIDTH-1:0] SAT_MIN = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic signed [WIDTH-1:0] ONE_VAL =
        (FRAC_BITS >= WIDTH - 1) ? SAT_MAX : (WIDTH'(1) << FRAC_BITS);

    logic [WIDTH-1:0]               l_mem [mm4_pkg::ELEM_COUNT];
    logic [WIDTH-1:0]               r_mem [mm4_pkg::ELEM_COUNT];
    logic [mm4_pkg::ELEM_COUNT-1:0] l_vld_reg;
    logic [mm4_pkg::ELEM_COUNT-1:0] r_vld_reg;

    logic [mm4_pkg::ELEM_W-1:0]     l_addr;
    logic [mm4_pkg::ELEM_W-1:0]     r_addr;

    // stage 1: read
    logic                           s1_v_reg;
    logic [mm4_pkg::ELEM_W-1:0]     s1_elem_reg;
    logic [mm4_pkg::TERM_W-1:0]     s1_term_reg;
    logic [WIDTH-1:0]               l_rd_reg;
    logic [WIDTH-1:0]               r_rd_reg;
    logic                           l_ok_reg;
    logic                           r_ok_reg;
    logic                           l_diag_reg;
    logic                           r_diag_reg;

    // stage 2: multiply
    logic signed [WIDTH-1:0]        l_op;
    logic signed [WIDTH-1:0]        r_op;
    logic                           s2_v_reg;
    logic [mm4_pkg::ELEM_W-1:0]     s2_elem_reg;
    logic [mm4_pkg::TERM_W-1:0]     s2_term_reg;
    logic signed [PROD_W-1:0]       prod_reg;

    // stage 3: accumulate
    logic                           s3_v_reg;
    logic [mm4_pkg::ELEM_W-1:0]     s3_elem_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [ACC_W-1:0]        acc_next;

    // stage 4: shift, saturate, present
    logic signed [ACC_W-1:0]        shifted;
    logic [ACC_W-WIDTH:0]           top_bits;
    logic signed [WIDTH-1:0]        sat_val;
    logic                           result_valid_reg;
    logic [1:0]                     out_row_reg;
    logic [1:0]                     out_col_reg;
    logic signed [31:0]             product_reg;
    logic                           last_reg;

    assign l_addr = {cmd.elem[3:2], cmd.term};
    assign r_addr = {cmd.term, cmd.elem[1:0]};

    always_ff @(posedge clk)
    begin
        if (cmd.wr_left)
            l_mem[cmd.wr_addr] <= value[WIDTH-1:0];
        if (cmd.wr_right)
            r_mem[cmd.wr_addr] <= value[WIDTH-1:0];
        l_rd_reg <= l_mem[l_addr];
        r_rd_reg <= r_mem[r_addr];
    end

    // entries never written read as identity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_vld_reg <= '0;
            r_vld_reg <= '0;
        end
        else
        begin
            if (cmd.wr_left)
                l_vld_reg[cmd.wr_addr] <= 1'b1;
            if (cmd.wr_right)
                r_vld_reg[cmd.wr_addr] <= 1'b1;
        end
    end

    assign l_op = l_ok_reg ? l_rd_reg : (l_diag_reg ? ONE_VAL : '0);
    assign r_op = r_ok_reg ? r_rd_reg : (r_diag_reg ? ONE_VAL : '0);

    assign acc_next = ((s2_term_reg == mm4_pkg::TERM_FIRST) ? ACC_W'(0) : acc_reg)
                    + ACC_W'(prod_reg);

    assign shifted  = acc_reg >>> FRAC_BITS;
    assign top_bits = shifted[ACC_W-1:WIDTH-1];

    always_comb
    begin
        if ((&top_bits) || !(|top_bits))
            sat_val = shifted[WIDTH-1:0];
        else if (shifted[ACC_W-1])
            sat_val = SAT_MIN;
        else
            sat_val = SAT_MAX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg         <= 1'b0;
            s2_v_reg         <= 1'b0;
            s3_v_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg         <= cmd.issue;
            s2_v_reg         <= s1_v_reg;
            s3_v_reg         <= s2_v_reg && (s2_term_reg == mm4_pkg::TERM_LAST);
            result_valid_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_elem_reg <= cmd.elem;
        s1_term_reg <= cmd.term;
        l_ok_reg    <= l_vld_reg[l_addr];
        r_ok_reg    <= r_vld_reg[r_addr];
        l_diag_reg  <= (l_addr[3:2] == l_addr[1:0]);
        r_diag_reg  <= (r_addr[3:2] == r_addr[1:0]);

        s2_elem_reg <= s1_elem_reg;
        s2_term_reg <= s1_term_reg;
        prod_reg    <= l_op * r_op;

        if (s2_v_reg)
        begin
            acc_reg     <= acc_next;
            s3_elem_reg <= s2_elem_reg;
        end

        out_row_reg <= s3_elem_reg[3:2];
        out_col_reg <= s3_elem_reg[1:0];
        product_reg <= 32'(sat_val);
        last_reg    <= (s3_elem_reg == mm4_pkg::ELEM_LAST);
    end

    assign stat.pipe_active = s1_v_reg || s2_v_reg || s3_v_reg;

    assign result_valid = result_valid_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign product      = product_reg;
    assign last         = last_reg;

endmodule

[design/matrix_multiply_4x4_core.sv]
// Write transactions (op 0/1) keep busy low, so one per cycle.
// A multiply transaction raises busy until the pipeline drains: one multiply-accumulate unit
// reads one left and one right element a cycle, so each product element sums four terms.
// The multiply yields 16 results in all.
// Results appear for one cycle on result_valid; the receiver cannot stall them.
// Reset (rst_n, async, active low) returns both matrices to identity and the core to idle.
module matrix_multiply_4x4_core #(
    parameter int WIDTH     = mm4_pkg::DEF_WIDTH,
    parameter int FRAC_BITS = mm4_pkg::DEF_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic [1:0]         row,
    input  logic [1:0]         col,
    input  logic signed [31:0] value,
    output logic               result_valid,
    output logic [1:0]         out_row,
    output logic [1:0]         out_col,
    output logic signed [31:0] product,
    output logic               last
);

    mm4_pkg::dp_cmd_t  cmd;
    mm4_pkg::dp_stat_t stat;

    mm4_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .row   (row),
        .col   (col),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    mm4_datapath #(
        .WIDTH     (WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .value        (value),
        .stat         (stat),
        .result_valid (result_valid),
        .out_row      (out_row),
        .out_col      (out_col),
        .product      (product),
        .last         (last)
    );

endmodule
